// ===== design/tlafk_pkg.sv =====
// Shared types and constants for the two-link arm forward kinematics block.
// Holds the controller/datapath command and status words and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package tlafk_pkg;

  // field widths
  localparam int ANG_W      = 16;
  localparam int LEN_W      = 16;
  localparam int POS_W      = 18;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  // cordic vector and angle width, Q2.30 and 2^32 units per turn
  localparam int VEC_W      = 32;
  localparam int STEP_IDX_W = 5;
  localparam int ATAN_LEN   = 24;
  localparam logic signed [VEC_W-1:0] GAIN_Q30 = 32'sd652032874;

  // products of a Q4.12 length and a Q2.30 vector value, and their sum
  localparam int PROD_W     = LEN_W + 1 + VEC_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_SHIFT = 30;
  localparam logic signed [POS_W-1:0] POS_MAX = 18'sd131071;
  localparam logic signed [POS_W-1:0] POS_MIN = -18'sd131072;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_OFS  = 8'd3;

  // reset values of the link lengths
  localparam logic [LEN_W-1:0] FIRST_LEN_RST  = 16'd7373;
  localparam logic [LEN_W-1:0] SECOND_LEN_RST = 16'd4096;

  // commands from controller to datapath
  typedef struct packed {
    logic                  capture;     // take input word, form offset angles
    logic                  store;       // remember the offset pair
    logic                  acc_clear;   // clear position sums
    logic                  cordic_load; // seed the rotation for the current run
    logic                  cordic_step; // one micro-rotation
    logic [STEP_IDX_W-1:0] step_idx;
    logic                  run_sel;     // 0: first link angle, 1: summed angle
    logic                  mul_x;       // length times cosine
    logic                  mul_y;       // add cosine product, length times sine
    logic                  acc_y;       // add sine product
    logic                  out_load;    // round, saturate and load output word
  } tlafk_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic changed;   // offset pair differs from the stored one, or none stored
    logic out_free;  // output register can take a new word this cycle
  } tlafk_sts_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [VEC_W-1:0] atan_lookup(input logic [STEP_IDX_W-1:0] idx);
    logic signed [VEC_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/tlafk_ctrl.sv =====
// Sequencer for the forward kinematics block: input handshake, change check,
// two CORDIC runs and the length multiplies. Depends on tlafk_pkg.
`default_nettype none

module tlafk_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire tlafk_pkg::tlafk_sts_t sts,
  output tlafk_pkg::tlafk_cmd_t      cmd
);
  import tlafk_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  // state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROT   = 3'd3;
  localparam logic [2:0] S_MULX  = 3'd4;
  localparam logic [2:0] S_MULY  = 3'd5;
  localparam logic [2:0] S_ACCY  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    cmd       = '0;
    cmd.run_sel  = run_r;
    cmd.step_idx = STEP_IDX_W'(cnt_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.changed) begin
          cmd.store     = 1'b1;
          cmd.acc_clear = 1'b1;
          run_nxt       = 1'b0;
          state_nxt     = S_LOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.cordic_load = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_ROT;
      end
      S_ROT: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MULX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_ACCY;
      end
      S_ACCY: begin
        cmd.acc_y = 1'b1;
        if (run_r) begin
          state_nxt = S_DONE;
        end else begin
          run_nxt   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      run_r   <= run_nxt;
    end
  end

  // an accepted word is always checked next
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted word not followed by change check");

  // last rotation step leads to the multiplies
  a_rot_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && cnt_r == CNT_LAST) |=> (state_r == S_MULX))
    else $error("rotation did not end after the last step");

  // datapath commands never overlap, apart from acc_clear, which comes with store
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.store, cmd.cordic_load, cmd.cordic_step,
              cmd.mul_x, cmd.mul_y, cmd.acc_y, cmd.out_load}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// ===== design/tlafk_dpath.sv =====
// Datapath for the forward kinematics block: configuration registers, stored
// angle pair, shared CORDIC rotator, length multiplier, sums and output register.
// Depends on tlafk_pkg.
`default_nettype none

module tlafk_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [tlafk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tlafk_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [tlafk_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [tlafk_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire tlafk_pkg::tlafk_cmd_t                cmd,
  output tlafk_pkg::tlafk_sts_t                     sts
);
  import tlafk_pkg::*;

  // configuration
  logic [LEN_W-1:0] len1_r, len2_r;
  logic [ANG_W-1:0] ofs1_r, ofs2_r;

  // captured word and stored pair
  logic [ANG_W-1:0] a1_r, a2_r, r1_r, r2_r;
  logic [ANG_W-1:0] stored1_r, stored2_r;
  logic             pair_stored_r;

  // rotator
  logic signed [VEC_W-1:0] x_r, y_r, z_r;
  logic signed [VEC_W-1:0] x_nxt, y_nxt, z_nxt;
  logic                    flip_r;
  logic [ANG_W-1:0]        run_ang;
  logic [ANG_W-1:0]        fold_ang;
  logic                    fold;

  // multiply and sums
  logic signed [LEN_W:0]    mul_a;
  logic signed [VEC_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r;
  logic signed [ACC_W-1:0]  addend;

  // output register
  logic                    out_valid_r;
  logic [ANG_W-1:0]        out_r1_r, out_r2_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r;

  // round to Q.12 and saturate to the output range
  function automatic logic signed [POS_W-1:0] to_pos(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]            sum;
    logic signed [ACC_W-FRAC_SHIFT-1:0] q;
    sum = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
    q   = sum[ACC_W-1:FRAC_SHIFT];
    if (q > (ACC_W - FRAC_SHIFT)'(POS_MAX)) begin
      return POS_MAX;
    end else if (q < (ACC_W - FRAC_SHIFT)'(POS_MIN)) begin
      return POS_MIN;
    end
    return q[POS_W-1:0];
  endfunction

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= FIRST_LEN_RST;
      len2_r <= SECOND_LEN_RST;
      ofs1_r <= '0;
      ofs2_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_LEN:  len1_r <= cfg_data;
        REG_SECOND_LEN: len2_r <= cfg_data;
        REG_FIRST_OFS:  ofs1_r <= cfg_data;
        REG_SECOND_OFS: ofs2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture angles and form offset pair
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a1_r <= in_tdata[ANG_W-1:0];
      a2_r <= in_tdata[2*ANG_W-1:ANG_W];
      r1_r <= in_tdata[ANG_W-1:0] + ofs1_r;
      r2_r <= in_tdata[2*ANG_W-1:ANG_W] + ofs2_r;
    end
  end

  // stored pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_stored_r <= 1'b0;
      stored1_r     <= '0;
      stored2_r     <= '0;
    end else if (cmd.store) begin
      pair_stored_r <= 1'b1;
      stored1_r     <= r1_r;
      stored2_r     <= r2_r;
    end
  end

  assign sts.changed  = !pair_stored_r || (r1_r != stored1_r) || (r2_r != stored2_r);
  assign sts.out_free = !out_valid_r || out_tready;

  // fold angle into a quarter turn either side of zero
  assign run_ang  = cmd.run_sel ? (a1_r + a2_r) : a1_r;
  assign fold     = run_ang[ANG_W-1] ^ run_ang[ANG_W-2];
  assign fold_ang = {run_ang[ANG_W-1] ^ fold, run_ang[ANG_W-2:0]};

  // one micro-rotation
  always_comb begin
    if (!z_r[VEC_W-1]) begin
      x_nxt = x_r - (y_r >>> cmd.step_idx);
      y_nxt = y_r + (x_r >>> cmd.step_idx);
      z_nxt = z_r - atan_lookup(cmd.step_idx);
    end else begin
      x_nxt = x_r + (y_r >>> cmd.step_idx);
      y_nxt = y_r - (x_r >>> cmd.step_idx);
      z_nxt = z_r + atan_lookup(cmd.step_idx);
    end
  end

  // rotator registers
  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      x_r    <= GAIN_Q30;
      y_r    <= '0;
      z_r    <= {fold_ang, {(VEC_W - ANG_W){1'b0}}};
      flip_r <= fold;
    end else if (cmd.cordic_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // length multiply, folded runs subtract instead of add
  assign mul_a  = $signed({1'b0, (cmd.run_sel ? len2_r : len1_r)});
  assign mul_b  = cmd.mul_y ? y_r : x_r;
  assign addend = flip_r ? -ACC_W'(prod_r) : ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // position sums
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (cmd.mul_y) begin
      acc_x_r <= acc_x_r + addend;
    end else if (cmd.acc_y) begin
      acc_y_r <= acc_y_r + addend;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r1_r <= r1_r;
      out_r2_r <= r2_r;
      out_x_r  <= to_pos(acc_x_r);
      out_y_r  <= to_pos(acc_y_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*ANG_W - 2*POS_W){1'b0}},
                       out_y_r, out_x_r, out_r2_r, out_r1_r};

  // a new word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output word overwritten before taken");

  // a stored pair suppresses an identical following pair
  a_store_then_same: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (pair_stored_r && !sts.changed))
    else $error("stored pair not seen as unchanged");

  // loading makes a word visible
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded word not presented");

endmodule

`default_nettype wire

// ===== design/two_link_arm_forward_kinematics.sv =====
// Top level of the two-link planar arm forward kinematics block.
// Joins the sequencer (tlafk_ctrl) and the datapath (tlafk_dpath); uses tlafk_pkg.
//
// Usage:
//   in_*   : joint angle words, tdata = {joint_angle_two, joint_angle_one}.
//   out_*  : result words, tdata = {pad, tip_y, tip_x, reported_angle_two,
//            reported_angle_one}. A word appears only when the offset angle
//            pair differs from the last stored pair, or for the first word.
//   cfg_*  : register writes (0 first link length, 1 second link length,
//            2 first angle offset, 3 second angle offset); cfg_ready is always
//            high, other indexes are dropped. Write only while the block is idle.
// Sequencing: a word whose pair is unchanged is checked and dropped, and then the next
//   can be taken. A changed pair makes two passes (first link angle, then summed angle),
//   each a load, the CORDIC steps and the two length multiplies, through the one shared
//   CORDIC rotator and the shared multiplier; no new word is accepted meanwhile.
//   The next word is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous) restores the register defaults, forgets the
//   stored pair and drops any pending result.
// A stalled receiver holds the result in the output register; the next
//   changed result waits until that word is taken.
`default_nettype none

module two_link_arm_forward_kinematics #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // joint_angle_one [15:0], joint_angle_two [31:16]
  input  wire logic [tlafk_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // reported_angle_one [15:0], reported_angle_two [31:16],
  // tip_x [49:32], tip_y [67:50], zero [71:68]
  output logic [tlafk_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tlafk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tlafk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tlafk_pkg::*;

  tlafk_cmd_t cmd;
  tlafk_sts_t sts;

  assign cfg_ready = 1'b1;

  tlafk_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlafk_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire
